// ===== rtl/chemostat_rk4_step_top_defines.svh =====
// Assertion macros used by the controller of the chemostat integrator.
// Each macro expects a clock named clk and a synchronous reset named rst in scope.
`ifndef CHEMOSTAT_RK4_STEP_TOP_DEFINES_SVH
`define CHEMOSTAT_RK4_STEP_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Checks that a condition holds at every clock edge outside reset.
`define CRK_ASSERT(name, cond) \
  name: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("invariant check failed");
// Checks that a trigger implies a consequence in the same cycle.
`define CRK_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");
// Checks that a trigger implies a consequence in the next cycle.
`define CRK_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define CRK_ASSERT(name, cond)
`define CRK_ASSERT_IMP(name, ante, cons)
`define CRK_ASSERT_NXT(name, ante, cons)
`endif
`endif

// ===== rtl/crk_pkg.sv =====
`timescale 1ns / 1ps
package crk_pkg;

  // Payload types.
  typedef struct packed {
    logic               action;
    logic signed [47:0] load_substrate;
    logic signed [47:0] load_biomass;
  } in_item_t;

  typedef struct packed {
    logic signed [47:0] substrate;
    logic signed [47:0] biomass;
    logic [1:0]         fault;
  } out_item_t;

  // Configuration register indexes.
  localparam logic [2:0] REG_KS = 3'd0;
  localparam logic [2:0] REG_KD = 3'd1;
  localparam logic [2:0] REG_MU = 3'd2;
  localparam logic [2:0] REG_UP = 3'd3;
  localparam logic [2:0] REG_SR = 3'd4;
  localparam logic [2:0] REG_DR = 3'd5;
  localparam logic [2:0] REG_DT = 3'd6;
  localparam int CFG_COUNT = 7;

  // Fault codes.
  localparam logic [1:0] FAULT_NONE = 2'd0;
  localparam logic [1:0] FAULT_DEN  = 2'd1;
  localparam logic [1:0] FAULT_SAT  = 2'd2;

  // Operation codes of the step program.
  localparam logic [2:0] OP_ADD    = 3'd0;
  localparam logic [2:0] OP_SUB    = 3'd1;
  localparam logic [2:0] OP_DEN    = 3'd2;
  localparam logic [2:0] OP_MUL    = 3'd3;
  localparam logic [2:0] OP_DIV    = 3'd4;
  localparam logic [2:0] OP_COMMIT = 3'd5;
  localparam logic [2:0] OP_END    = 3'd6;

  // Operand sources: codes below 32 name scratch memory entries.
  localparam logic [5:0] R_SP  = 6'd0;
  localparam logic [5:0] R_XP  = 6'd1;
  localparam logic [5:0] R_DEN = 6'd2;
  localparam logic [5:0] R_G   = 6'd3;
  localparam logic [5:0] R_GX  = 6'd4;
  localparam logic [5:0] R_T1  = 6'd5;
  localparam logic [5:0] R_T2  = 6'd6;
  localparam logic [5:0] R_K1S = 6'd7;
  localparam logic [5:0] R_K1X = 6'd8;
  localparam logic [5:0] R_K2S = 6'd9;
  localparam logic [5:0] R_K2X = 6'd10;
  localparam logic [5:0] R_K3S = 6'd11;
  localparam logic [5:0] R_K3X = 6'd12;
  localparam logic [5:0] R_K4S = 6'd13;
  localparam logic [5:0] R_K4X = 6'd14;
  localparam logic [5:0] R_TS  = 6'd15;
  localparam logic [5:0] R_TX  = 6'd16;
  localparam logic [5:0] R_DT6 = 6'd17;
  localparam logic [5:0] R_NS  = 6'd18;
  localparam logic [5:0] R_NX  = 6'd19;

  localparam logic [5:0] SRC_S    = 6'd32;
  localparam logic [5:0] SRC_X    = 6'd33;
  localparam logic [5:0] SRC_KS   = 6'd34;
  localparam logic [5:0] SRC_KD   = 6'd35;
  localparam logic [5:0] SRC_MU   = 6'd36;
  localparam logic [5:0] SRC_UP   = 6'd37;
  localparam logic [5:0] SRC_SR   = 6'd38;
  localparam logic [5:0] SRC_DR   = 6'd39;
  localparam logic [5:0] SRC_DT   = 6'd40;
  localparam logic [5:0] SRC_DT2  = 6'd41;
  localparam logic [5:0] SRC_ZERO = 6'd42;
  localparam logic [5:0] SRC_SIX  = 6'd43;

  localparam logic [6:0] PC_END = 7'd70;

  typedef struct packed {
    logic [2:0] op;
    logic [5:0] dst;
    logic [5:0] a;
    logic [5:0] b;
  } instr_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic   load;
    logic   begin_step;
    logic   issue;
    logic   start;
    logic   post;
    instr_t instr;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic done;
    logic out_full;
  } status_t;

  function automatic instr_t mk(logic [2:0] op, logic [5:0] dst, logic [5:0] a,
                                logic [5:0] b);
    instr_t r;
    r.op  = op;
    r.dst = dst;
    r.a   = a;
    r.b   = b;
    return r;
  endfunction

  // One derivative evaluation at point (ps, px), results into (dks, dkx).
  function automatic instr_t eval_instr(logic [3:0] i, logic [5:0] ps, logic [5:0] px,
                                        logic [5:0] dks, logic [5:0] dkx);
    instr_t r;
    case (i)
      4'd0:    r = mk(OP_DEN, R_DEN, SRC_KS, ps);
      4'd1:    r = mk(OP_DIV, R_G, ps, R_DEN);
      4'd2:    r = mk(OP_MUL, R_GX, R_G, px);
      4'd3:    r = mk(OP_MUL, R_T1, SRC_MU, R_GX);
      4'd4:    r = mk(OP_MUL, R_T2, SRC_KD, px);
      4'd5:    r = mk(OP_SUB, dkx, R_T1, R_T2);
      4'd6:    r = mk(OP_MUL, R_T1, SRC_SR, SRC_DR);
      4'd7:    r = mk(OP_MUL, R_T2, SRC_DR, ps);
      4'd8:    r = mk(OP_SUB, R_T1, R_T1, R_T2);
      4'd9:    r = mk(OP_MUL, R_T2, SRC_UP, R_GX);
      4'd10:   r = mk(OP_SUB, dks, R_T1, R_T2);
      default: r = mk(OP_END, R_SP, SRC_ZERO, SRC_ZERO);
    endcase
    return r;
  endfunction

  // A point along the step: (ds, dx) = (S, X) + h * (ks, kx).
  function automatic instr_t stage_instr(logic [1:0] i, logic [5:0] h, logic [5:0] ks,
                                         logic [5:0] kx, logic [5:0] ds, logic [5:0] dx);
    instr_t r;
    case (i)
      2'd0:    r = mk(OP_MUL, R_T1, h, ks);
      2'd1:    r = mk(OP_ADD, ds, SRC_S, R_T1);
      2'd2:    r = mk(OP_MUL, R_T1, h, kx);
      default: r = mk(OP_ADD, dx, SRC_X, R_T1);
    endcase
    return r;
  endfunction

  // Weighted sum k1 + 2*(k2+k3) + k4 in the order that fixes saturation.
  function automatic instr_t sum_instr(logic [2:0] i);
    instr_t r;
    case (i)
      3'd0:    r = mk(OP_ADD, R_TS, R_K2S, R_K3S);
      3'd1:    r = mk(OP_ADD, R_TS, R_TS, R_TS);
      3'd2:    r = mk(OP_ADD, R_TS, R_TS, R_K1S);
      3'd3:    r = mk(OP_ADD, R_TS, R_TS, R_K4S);
      3'd4:    r = mk(OP_ADD, R_TX, R_K2X, R_K3X);
      3'd5:    r = mk(OP_ADD, R_TX, R_TX, R_TX);
      3'd6:    r = mk(OP_ADD, R_TX, R_TX, R_K1X);
      default: r = mk(OP_ADD, R_TX, R_TX, R_K4X);
    endcase
    return r;
  endfunction

  // The step program.
  function automatic instr_t rom(logic [6:0] pc);
    logic [6:0] off;
    instr_t     r;
    off = 7'd0;
    if (pc == 7'd0) begin
      r = mk(OP_DIV, R_DT6, SRC_DT, SRC_SIX);
    end else if (pc <= 7'd11) begin
      off = pc - 7'd1;
      r = eval_instr(off[3:0], SRC_S, SRC_X, R_K1S, R_K1X);
    end else if (pc <= 7'd15) begin
      off = pc - 7'd12;
      r = stage_instr(off[1:0], SRC_DT2, R_K1S, R_K1X, R_SP, R_XP);
    end else if (pc <= 7'd26) begin
      off = pc - 7'd16;
      r = eval_instr(off[3:0], R_SP, R_XP, R_K2S, R_K2X);
    end else if (pc <= 7'd30) begin
      off = pc - 7'd27;
      r = stage_instr(off[1:0], SRC_DT2, R_K2S, R_K2X, R_SP, R_XP);
    end else if (pc <= 7'd41) begin
      off = pc - 7'd31;
      r = eval_instr(off[3:0], R_SP, R_XP, R_K3S, R_K3X);
    end else if (pc <= 7'd45) begin
      off = pc - 7'd42;
      r = stage_instr(off[1:0], SRC_DT, R_K3S, R_K3X, R_SP, R_XP);
    end else if (pc <= 7'd56) begin
      off = pc - 7'd46;
      r = eval_instr(off[3:0], R_SP, R_XP, R_K4S, R_K4X);
    end else if (pc <= 7'd64) begin
      off = pc - 7'd57;
      r = sum_instr(off[2:0]);
    end else if (pc <= 7'd68) begin
      off = pc - 7'd65;
      r = stage_instr(off[1:0], R_DT6, R_TS, R_TX, R_NS, R_NX);
    end else if (pc == 7'd69) begin
      r = mk(OP_COMMIT, R_SP, R_NS, R_NX);
    end else begin
      r = mk(OP_END, R_SP, SRC_ZERO, SRC_ZERO);
    end
    return r;
  endfunction

  // Saturate a magnitude with sign; the top bit of the result flags overflow.
  function automatic logic [48:0] sat_mag(logic [71:0] m, logic neg);
    logic [71:0] lim;
    logic [47:0] v;
    lim = neg ? 72'h8000_0000_0000 : 72'h7FFF_FFFF_FFFF;
    v = neg ? (48'd0 - m[47:0]) : m[47:0];
    if (m > lim) begin
      return {1'b1, (neg ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF)};
    end
    return {1'b0, v};
  endfunction

  // Saturate a 49-bit signed sum to 48 bits; the top bit flags overflow.
  function automatic logic [48:0] sat_sum(logic [48:0] v);
    if (v[48] != v[47]) begin
      return {1'b1, (v[48] ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF)};
    end
    return {1'b0, v[47:0]};
  endfunction

endpackage

// ===== rtl/crk_datapath.sv =====
`timescale 1ns / 1ps
module crk_datapath (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [46:0]         cfg_data,
  input  crk_pkg::in_item_t   in_data,
  input  logic                out_stall,
  output logic                out_valid,
  output crk_pkg::out_item_t  out_data,
  input  crk_pkg::cmd_t       cmd,
  output crk_pkg::status_t    status
);

  logic [46:0]        cfg_reg [crk_pkg::CFG_COUNT];
  logic signed [47:0] s_level;
  logic signed [47:0] x_level;
  logic [47:0]        rf [32];
  logic [47:0]        rda;
  logic [47:0]        rdb;
  logic [47:0]        va;
  logic [47:0]        vb;
  logic [47:0]        ma;
  logic [47:0]        mb;
  logic               busy;
  logic [2:0]         cur_op;
  logic [4:0]         dst;
  logic [6:0]         cnt;
  logic [47:0]        opa;
  logic [47:0]        opb;
  logic [47:0]        mag_a;
  logic [47:0]        mag_b;
  logic               neg;
  logic [95:0]        acc;
  logic [71:0]        nq;
  logic [47:0]        rem;
  logic               ovf;
  logic               badden;
  logic               stepped;
  logic               done;
  logic [47:0]        pp;
  logic [95:0]        pp_sh;
  logic [48:0]        trial;
  logic               qbit;
  logic [48:0]        res;
  logic               den_bad;
  logic [48:0]        sum49;
  logic [1:0]         fault;

  // Operand source selection.
  function automatic logic [47:0] pick(logic [5:0] src, logic [47:0] rd,
                                       logic [47:0] s, logic [47:0] x,
                                       logic [46:0] ks, logic [46:0] kd,
                                       logic [46:0] mu, logic [46:0] up,
                                       logic [46:0] sr, logic [46:0] dr,
                                       logic [46:0] dt);
    logic [47:0] v;
    if (!src[5]) begin
      v = rd;
    end else begin
      case (src)
        crk_pkg::SRC_S:   v = s;
        crk_pkg::SRC_X:   v = x;
        crk_pkg::SRC_KS:  v = {1'b0, ks};
        crk_pkg::SRC_KD:  v = {1'b0, kd};
        crk_pkg::SRC_MU:  v = {1'b0, mu};
        crk_pkg::SRC_UP:  v = {1'b0, up};
        crk_pkg::SRC_SR:  v = {1'b0, sr};
        crk_pkg::SRC_DR:  v = {1'b0, dr};
        crk_pkg::SRC_DT:  v = {1'b0, dt};
        crk_pkg::SRC_DT2: v = {2'b00, dt[46:1]};
        crk_pkg::SRC_SIX: v = 48'd6 << 24;
        default:          v = 48'd0;
      endcase
    end
    return v;
  endfunction

  always_comb begin
    va = pick(cmd.instr.a, rda, s_level, x_level, cfg_reg[crk_pkg::REG_KS],
              cfg_reg[crk_pkg::REG_KD], cfg_reg[crk_pkg::REG_MU], cfg_reg[crk_pkg::REG_UP],
              cfg_reg[crk_pkg::REG_SR], cfg_reg[crk_pkg::REG_DR], cfg_reg[crk_pkg::REG_DT]);
    vb = pick(cmd.instr.b, rdb, s_level, x_level, cfg_reg[crk_pkg::REG_KS],
              cfg_reg[crk_pkg::REG_KD], cfg_reg[crk_pkg::REG_MU], cfg_reg[crk_pkg::REG_UP],
              cfg_reg[crk_pkg::REG_SR], cfg_reg[crk_pkg::REG_DR], cfg_reg[crk_pkg::REG_DT]);
    ma = va[47] ? (48'd0 - va) : va;
    mb = vb[47] ? (48'd0 - vb) : vb;
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_reg[crk_pkg::REG_KS] <= 47'd16777216;
      cfg_reg[crk_pkg::REG_KD] <= 47'd50332;
      cfg_reg[crk_pkg::REG_MU] <= 47'd16777216;
      cfg_reg[crk_pkg::REG_UP] <= 47'd5368709;
      cfg_reg[crk_pkg::REG_SR] <= 47'd1677721600;
      cfg_reg[crk_pkg::REG_DR] <= 47'd167772;
      cfg_reg[crk_pkg::REG_DT] <= 47'd1677722;
    end else if (cfg_we && (cfg_index < 3'(crk_pkg::CFG_COUNT))) begin
      cfg_reg[cfg_index] <= cfg_data;
    end
  end

  // One partial product of the multiplier: 24 by 24 bits per cycle.
  always_comb begin
    pp = 48'((cnt[1] ? mag_a[47:24] : mag_a[23:0]) * (cnt[0] ? mag_b[47:24] : mag_b[23:0]));
    case ({cnt[1], cnt[0]})
      2'b00:   pp_sh = {48'd0, pp};
      2'b11:   pp_sh = {pp, 48'd0};
      default: pp_sh = {24'd0, pp, 24'd0};
    endcase
  end

  // One restoring division step.
  always_comb begin
    trial = {rem, nq[71]};
    qbit  = trial >= {1'b0, opb};
  end

  // Completion and result formation.
  always_comb begin
    done = 1'b0;
    if (busy) begin
      case (cur_op)
        crk_pkg::OP_MUL: done = (cnt == 7'd4);
        crk_pkg::OP_DIV: done = (cnt == 7'd72);
        default:         done = 1'b1;
      endcase
    end
    sum49   = 49'd0;
    den_bad = 1'b0;
    case (cur_op)
      crk_pkg::OP_ADD: begin
        sum49 = {opa[47], opa} + {opb[47], opb};
        res   = crk_pkg::sat_sum(sum49);
      end
      crk_pkg::OP_SUB: begin
        sum49 = {opa[47], opa} - {opb[47], opb};
        res   = crk_pkg::sat_sum(sum49);
      end
      crk_pkg::OP_DEN: begin
        sum49   = {opa[47], opa} + {opb[47], opb};
        den_bad = sum49[48] || (sum49 == 49'd0);
        res     = {1'b0, sum49[47:0]};
      end
      crk_pkg::OP_MUL: res = crk_pkg::sat_mag(acc[95:24], neg);
      crk_pkg::OP_DIV: res = crk_pkg::sat_mag(nq, neg);
      default:         res = 49'd0;
    endcase
    if (!stepped) begin
      fault = crk_pkg::FAULT_NONE;
    end else if (badden) begin
      fault = crk_pkg::FAULT_DEN;
    end else if (ovf) begin
      fault = crk_pkg::FAULT_SAT;
    end else begin
      fault = crk_pkg::FAULT_NONE;
    end
  end

  // Scratch memory: one write port, two registered read ports.
  always_ff @(posedge clk) begin
    if (done && (cur_op != crk_pkg::OP_COMMIT)) begin
      rf[dst] <= res[47:0];
    end
    if (cmd.issue) begin
      rda <= rf[cmd.instr.a[4:0]];
      rdb <= rf[cmd.instr.b[4:0]];
    end
  end

  // Arithmetic unit operand and iteration registers.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      opa    <= va;
      opb    <= vb;
      mag_a  <= ma;
      mag_b  <= mb;
      neg    <= (cmd.instr.op == crk_pkg::OP_DIV) ? va[47] : (va[47] ^ vb[47]);
      cur_op <= cmd.instr.op;
      dst    <= cmd.instr.dst[4:0];
      cnt    <= 7'd0;
      acc    <= 96'd0;
      nq     <= {ma, 24'd0};
      rem    <= 48'd0;
    end else if (busy && !done) begin
      cnt <= cnt + 7'd1;
      if (cur_op == crk_pkg::OP_MUL) begin
        acc <= acc + pp_sh;
      end else begin
        nq  <= {nq[70:0], qbit};
        rem <= qbit ? 48'(trial - {1'b0, opb}) : trial[47:0];
      end
    end
  end

  // State, flags and the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      s_level   <= '0;
      x_level   <= '0;
      ovf       <= 1'b0;
      badden    <= 1'b0;
      stepped   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.start) begin
        busy <= 1'b1;
      end else if (done) begin
        busy <= 1'b0;
      end
      if (cmd.load) begin
        s_level <= in_data.load_substrate;
        x_level <= in_data.load_biomass;
        stepped <= 1'b0;
      end
      if (cmd.begin_step) begin
        ovf     <= 1'b0;
        badden  <= 1'b0;
        stepped <= 1'b1;
      end else if (done) begin
        if (cur_op == crk_pkg::OP_COMMIT) begin
          if (!badden) begin
            s_level <= opa;
            x_level <= opb;
          end
        end else begin
          ovf    <= ovf | res[48];
          badden <= badden | den_bad;
        end
      end
      if (cmd.post) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.post) begin
      out_data.substrate <= s_level;
      out_data.biomass   <= x_level;
      out_data.fault     <= fault;
    end
  end

  assign status.done     = done;
  assign status.out_full = out_valid;

endmodule

// ===== rtl/crk_controller.sv =====
`timescale 1ns / 1ps
`include "chemostat_rk4_step_top_defines.svh"
module crk_controller (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_action,
  output logic              in_stall,
  input  logic              out_stall,
  input  crk_pkg::status_t  status,
  output crk_pkg::cmd_t     cmd
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ISSUE = 3'd1;
  localparam logic [2:0] ST_EXEC  = 3'd2;
  localparam logic [2:0] ST_WAIT  = 3'd3;
  localparam logic [2:0] ST_POST  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic [6:0] pc;
  logic [6:0] pc_next;
  logic       accept;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  // Sequencing of the step program and of the result transfer.
  always_comb begin
    state_next     = state;
    pc_next        = pc;
    cmd.load       = 1'b0;
    cmd.begin_step = 1'b0;
    cmd.issue      = 1'b0;
    cmd.start      = 1'b0;
    cmd.post       = 1'b0;
    cmd.instr      = crk_pkg::rom(pc);
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (in_action) begin
            cmd.begin_step = 1'b1;
            pc_next        = 7'd0;
            state_next     = ST_ISSUE;
          end else begin
            cmd.load   = 1'b1;
            state_next = ST_POST;
          end
        end
      end
      ST_ISSUE: begin
        cmd.issue  = 1'b1;
        state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (cmd.instr.op == crk_pkg::OP_END) begin
          state_next = ST_POST;
        end else begin
          cmd.start  = 1'b1;
          state_next = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (status.done) begin
          pc_next    = pc + 7'd1;
          state_next = ST_ISSUE;
        end
      end
      ST_POST: begin
        if (!status.out_full || !out_stall) begin
          cmd.post   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pc    <= 7'd0;
    end else begin
      state <= state_next;
      pc    <= pc_next;
    end
  end

  `CRK_ASSERT_IMP(a_done_in_wait, status.done, state == ST_WAIT)
  `CRK_ASSERT_IMP(a_post_no_overwrite, cmd.post, !(status.out_full && out_stall))
  `CRK_ASSERT_NXT(a_exec_then_wait, state == ST_EXEC, state == ST_WAIT || state == ST_POST)
  `CRK_ASSERT(a_pc_in_program, pc <= crk_pkg::PC_END)

endmodule

// ===== rtl/chemostat_rk4_step_top.sv =====
`timescale 1ns / 1ps
// A load item passes through the ST_POST state to the result register; a step item runs the step program first.
// A step runs 70 program operations on one shared unit; the five divisions dominate.
// One item at a time: the next input transfer is taken once the result is queued.
// The result register lets the next item start while a result waits for its transfer.
// Reset (rst, synchronous) restores the configuration defaults and clears substrate and biomass.
module chemostat_rk4_step_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [46:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  crk_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output crk_pkg::out_item_t out_data
);

  crk_pkg::cmd_t    cmd;
  crk_pkg::status_t status;

  // Sequencer.
  crk_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_action (in_data.action),
    .in_stall  (in_stall),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // Arithmetic, state and result register.
  crk_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

// ===== test/chemostat_rk4_step_top_test.sv =====
`timescale 1ns / 1ps
module chemostat_rk4_step_top_test;

  localparam logic signed [47:0] VMAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] VMIN = 48'sh8000_0000_0000;
  localparam logic [46:0] ONE = 47'd16777216;
  localparam int WATCHDOG_LIMIT = 20000;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [46:0] cfg_data;
  logic in_valid;
  logic in_stall;
  crk_pkg::in_item_t in_data;
  logic out_valid;
  logic out_stall;
  crk_pkg::out_item_t out_data;

  chemostat_rk4_step_top u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // Predictor copy of the block's registers and state.
  logic [46:0] coef [crk_pkg::CFG_COUNT];
  logic signed [47:0] sub_level;
  logic signed [47:0] bio_level;
  logic sat_seen;
  logic den_bad;

  crk_pkg::in_item_t pending_items[$];
  crk_pkg::out_item_t expected_results[$];
  int errors;
  int steps_sent;
  int loads_sent;
  int faults_seen[3];
  int idle_cycles;
  bit idling_on;
  bit hold_out;
  bit in_taken;
  int long_hold;

  // Saturate a signed wide value to the 48-bit range.
  function automatic logic signed [47:0] clamp(logic signed [127:0] v);
    if (v > 128'(VMAX)) begin
      sat_seen = 1'b1;
      return VMAX;
    end
    if (v < 128'sd0 - 128'sd140737488355328) begin
      sat_seen = 1'b1;
      return VMIN;
    end
    return v[47:0];
  endfunction

  function automatic logic signed [47:0] q_add(logic signed [47:0] a, logic signed [47:0] b);
    return clamp(128'(a) + 128'(b));
  endfunction

  function automatic logic signed [47:0] q_sub(logic signed [47:0] a, logic signed [47:0] b);
    return clamp(128'(a) - 128'(b));
  endfunction

  // Magnitude product, truncated toward zero, sign applied afterwards.
  function automatic logic signed [47:0] q_mul(logic signed [47:0] a, logic signed [47:0] b);
    logic [127:0] ma;
    logic [127:0] mb;
    logic [127:0] p;
    ma = a < 0 ? 128'(-128'(a)) : 128'(a);
    mb = b < 0 ? 128'(-128'(b)) : 128'(b);
    p = (ma * mb) >> 24;
    if ((a < 0) != (b < 0)) return clamp(-$signed(p));
    return clamp($signed(p));
  endfunction

  // The divisor is positive and may use all 48 bits plus a carry.
  function automatic logic signed [47:0] q_div(logic signed [47:0] a, logic [63:0] d);
    logic [127:0] ma;
    logic [127:0] q;
    ma = a < 0 ? 128'(-128'(a)) : 128'(a);
    q = (ma << 24) / 128'(d);
    if (a < 0) return clamp(-$signed(q));
    return clamp($signed(q));
  endfunction

  // Monod derivatives at one point.
  task automatic rates(input logic signed [47:0] s, input logic signed [47:0] x,
                       output logic signed [47:0] ds, output logic signed [47:0] dx);
    logic signed [63:0] den;
    logic signed [47:0] g;
    logic signed [47:0] gx;
    den = 64'(coef[crk_pkg::REG_KS]) + 64'(s);
    if (den <= 0) begin
      den_bad = 1'b1;
      ds = '0;
      dx = '0;
    end else begin
      g = q_div(s, den);
      gx = q_mul(g, x);
      dx = q_sub(q_mul($signed({1'b0, coef[crk_pkg::REG_MU]}), gx),
                 q_mul($signed({1'b0, coef[crk_pkg::REG_KD]}), x));
      ds = q_sub(q_sub(q_mul($signed({1'b0, coef[crk_pkg::REG_SR]}),
                             $signed({1'b0, coef[crk_pkg::REG_DR]})),
                       q_mul($signed({1'b0, coef[crk_pkg::REG_DR]}), s)),
                 q_mul($signed({1'b0, coef[crk_pkg::REG_UP]}), gx));
    end
  endtask

  // One item into the predictor; the expected result is queued.
  task automatic predict_rk4(input crk_pkg::in_item_t it);
    crk_pkg::out_item_t r;
    logic signed [47:0] h;
    logic signed [47:0] h2;
    logic signed [47:0] h6;
    logic signed [47:0] s1, x1, s2, x2, s3, x3, s4, x4, ts, tx, ns, nx;
    r.fault = crk_pkg::FAULT_NONE;
    if (!it.action) begin
      sub_level = it.load_substrate;
      bio_level = it.load_biomass;
    end else begin
      h = $signed({1'b0, coef[crk_pkg::REG_DT]});
      h2 = h >>> 1;
      h6 = h / 6;
      sat_seen = 1'b0;
      den_bad = 1'b0;
      rates(sub_level, bio_level, s1, x1);
      rates(q_add(sub_level, q_mul(h2, s1)), q_add(bio_level, q_mul(h2, x1)), s2, x2);
      rates(q_add(sub_level, q_mul(h2, s2)), q_add(bio_level, q_mul(h2, x2)), s3, x3);
      rates(q_add(sub_level, q_mul(h, s3)), q_add(bio_level, q_mul(h, x3)), s4, x4);
      ts = q_add(s2, s3);
      ts = q_add(q_add(q_add(ts, ts), s1), s4);
      tx = q_add(x2, x3);
      tx = q_add(q_add(q_add(tx, tx), x1), x4);
      ns = q_add(sub_level, q_mul(h6, ts));
      nx = q_add(bio_level, q_mul(h6, tx));
      if (den_bad) begin
        r.fault = crk_pkg::FAULT_DEN;
      end else begin
        sub_level = ns;
        bio_level = nx;
        if (sat_seen) r.fault = crk_pkg::FAULT_SAT;
      end
    end
    r.substrate = sub_level;
    r.biomass = bio_level;
    expected_results.push_back(r);
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Driver: holds an offered item until its transfer, then offers the next or idles.
  int gap_left;
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_left = 0;
      in_taken = 1'b0;
    end else if (in_taken || !in_valid) begin
      in_taken = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        if (idling_on && $urandom_range(0, 6) == 0) begin
          gap_left = $urandom_range(0, 8);
          in_valid <= 1'b0;
        end else begin
          in_valid <= 1'b1;
          in_data <= pending_items[0];
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Predict each input transfer at the rising edge.
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      predict_rk4(in_data);
      void'(pending_items.pop_front());
      in_taken = 1'b1;
      if (in_data.action) steps_sent++;
      else loads_sent++;
    end
  end

  // Receiver stall: random bursts, plus one long hold-off.
  int stall_left;
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (hold_out) begin
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (idling_on && $urandom_range(0, 6) == 0) begin
      stall_left = $urandom_range(0, 8);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Monitor: compare each result transfer with the oldest expectation.
  always @(posedge clk) begin
    crk_pkg::out_item_t e;
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result s=%h x=%h f=%0d", $time,
                 out_data.substrate, out_data.biomass, out_data.fault);
        errors++;
      end else begin
        e = expected_results.pop_front();
        if (out_data.fault <= 2) faults_seen[out_data.fault]++;
        if (out_data.substrate !== e.substrate) begin
          $display("%0t: substrate expected %h actual %h", $time, e.substrate,
                   out_data.substrate);
          errors++;
        end
        if (out_data.biomass !== e.biomass) begin
          $display("%0t: biomass expected %h actual %h", $time, e.biomass, out_data.biomass);
          errors++;
        end
        if (out_data.fault !== e.fault) begin
          $display("%0t: fault expected %0d actual %0d", $time, e.fault, out_data.fault);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (pending_items.size() > 0 || expected_results.size() > 0) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired", $time);
        $display("chemostat_rk4_step_top_test failed");
        $finish;
      end
    end
  end

  function automatic crk_pkg::in_item_t mk_load(logic signed [47:0] s, logic signed [47:0] x);
    crk_pkg::in_item_t it;
    it.action = 1'b0;
    it.load_substrate = s;
    it.load_biomass = x;
    return it;
  endfunction

  function automatic crk_pkg::in_item_t mk_step();
    crk_pkg::in_item_t it;
    it.action = 1'b1;
    it.load_substrate = 48'({$urandom, $urandom});
    it.load_biomass = 48'({$urandom, $urandom});
    return it;
  endfunction

  // Random value near a scale: mostly modest, sometimes any 48-bit pattern.
  function automatic logic signed [47:0] rand_val();
    logic signed [47:0] v;
    case ($urandom_range(0, 9))
      0: v = 48'({$urandom, $urandom});
      1: v = -$signed(48'($urandom_range(0, 1 << 30)));
      default: v = 48'($urandom_range(0, 32'h7FFF_FFFF)) << $urandom_range(0, 8);
    endcase
    return v;
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [46:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    coef[idx] = val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_items.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic reset_coefs();
    coef[crk_pkg::REG_KS] = 47'd16777216;
    coef[crk_pkg::REG_KD] = 47'd50332;
    coef[crk_pkg::REG_MU] = 47'd16777216;
    coef[crk_pkg::REG_UP] = 47'd5368709;
    coef[crk_pkg::REG_SR] = 47'd1677721600;
    coef[crk_pkg::REG_DR] = 47'd167772;
    coef[crk_pkg::REG_DT] = 47'd1677722;
  endtask

  task automatic random_phase(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 4) == 0) pending_items.push_back(mk_load(rand_val(), rand_val()));
      else pending_items.push_back(mk_step());
    end
  endtask

  initial begin
    errors = 0;
    steps_sent = 0;
    loads_sent = 0;
    idling_on = 1'b1;
    hold_out = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = crk_pkg::REG_KS;
    cfg_data = '0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    sub_level = '0;
    bio_level = '0;
    reset_coefs();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: defaults, field extremes, nonpositive denominator, saturation.
    pending_items.push_back(mk_step());
    pending_items.push_back(mk_load(48'sd16777216, 48'sd8388608));
    repeat (3) pending_items.push_back(mk_step());
    pending_items.push_back(mk_load(VMAX, VMAX));
    pending_items.push_back(mk_step());
    pending_items.push_back(mk_load(VMIN, VMIN));
    pending_items.push_back(mk_step());
    pending_items.push_back(mk_load(-48'sd16777216, 48'sd1000));
    pending_items.push_back(mk_step());
    pending_items.push_back(mk_load(-48'sd33554432, -48'sd5));
    pending_items.push_back(mk_step());
    pending_items.push_back(mk_load(48'sd0, -48'sd1));
    pending_items.push_back(mk_step());
    pending_items.push_back(mk_load(48'sh5555_5555_5555, 48'shAAAA_AAAA_AAAA));
    pending_items.push_back(mk_step());
    wait_drained();

    // Register extremes: largest values saturate, smallest give slow dynamics.
    write_reg(crk_pkg::REG_KS, 47'd1);
    write_reg(crk_pkg::REG_KD, 47'h7FFF_FFFF_FFFF);
    write_reg(crk_pkg::REG_MU, 47'h7FFF_FFFF_FFFF);
    write_reg(crk_pkg::REG_UP, 47'h7FFF_FFFF_FFFF);
    write_reg(crk_pkg::REG_SR, 47'h7FFF_FFFF_FFFF);
    write_reg(crk_pkg::REG_DR, 47'h7FFF_FFFF_FFFF);
    write_reg(crk_pkg::REG_DT, 47'h7FFF_FFFF_FFFF);
    pending_items.push_back(mk_load(48'sd16777216, 48'sd16777216));
    pending_items.push_back(mk_step());
    pending_items.push_back(mk_load(48'sd0, 48'sd0));
    pending_items.push_back(mk_step());
    wait_drained();
    write_reg(crk_pkg::REG_KD, 47'd0);
    write_reg(crk_pkg::REG_MU, 47'd0);
    write_reg(crk_pkg::REG_UP, 47'd0);
    write_reg(crk_pkg::REG_SR, 47'd0);
    write_reg(crk_pkg::REG_DR, 47'd0);
    write_reg(crk_pkg::REG_DT, 47'd0);
    pending_items.push_back(mk_load(48'sd100, 48'sd100));
    pending_items.push_back(mk_step());
    wait_drained();

    // Random phases over several register settings.
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(crk_pkg::REG_KS, ph == 0 ? ONE :
                47'($urandom_range(1, 32'h7FFF_FFFF)) << $urandom_range(0, 10));
      write_reg(crk_pkg::REG_KD, 47'($urandom_range(0, 1 << 24)));
      write_reg(crk_pkg::REG_MU, 47'($urandom_range(0, 1 << 26)));
      write_reg(crk_pkg::REG_UP, 47'($urandom_range(0, 1 << 25)));
      write_reg(crk_pkg::REG_SR, 47'($urandom) << $urandom_range(0, 6));
      write_reg(crk_pkg::REG_DR, 47'($urandom_range(0, 1 << 24)));
      write_reg(crk_pkg::REG_DT, ph == 5 ? 47'h7FFF_FFFF_FFFF :
                47'($urandom_range(0, 1 << 26)));
      if (ph == 2) begin
        // Long receiver hold-off while the sender keeps offering.
        hold_out = 1'b1;
        random_phase(20);
        long_hold = 0;
        while (long_hold < 3000) begin
          @(posedge clk);
          long_hold++;
        end
        hold_out = 1'b0;
      end
      if (ph == 5) idling_on = 1'b0;
      random_phase(270);
      wait_drained();
    end

    $display("Sent %0d loads and %0d steps over nine register settings.", loads_sent,
             steps_sent);
    $display("Faults seen: none %0d, denominator %0d, saturation %0d.", faults_seen[0],
             faults_seen[1], faults_seen[2]);
    if (errors == 0) begin
      $display("chemostat_rk4_step_top_test passed");
    end else begin
      $display("chemostat_rk4_step_top_test failed");
    end
    $finish;
  end
endmodule
